/* design/lbp_pkg.sv */
// Shared types and constants for the LSB-first bit packer.
// Used by lbp_ctrl, lbp_dpath and lsb_first_bit_packer; no dependencies.
`default_nettype none

package lbp_pkg;

  localparam int VALUE_W        = 64;
  localparam int CNT_W          = 7;
  localparam int BYTE_W         = 8;
  localparam int VB_W           = 4;
  localparam int TOT_W          = 32;
  localparam int PEND_W         = 7;
  localparam int PCNT_W         = 3;
  localparam int SREG_W         = VALUE_W + PEND_W;
  localparam int MAX_CHUNK_BITS = 64;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic load;
    logic emit_full;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic has_byte;
    logic part_emit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/lbp_ctrl.sv */
// Controller for the bit packer: sequences load, byte emission and finish.
// Depends on lbp_pkg; drives lbp_dpath through cmd_t, reads sts_t.
`default_nettype none

module lbp_ctrl
  import lbp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.has_byte) begin
          cmd.emit_full = sts.out_free;
        end else if (!sts.part_emit || sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lbp_dpath.sv */
// Datapath for the bit packer: stream shift register, pending byte, bit count
// and output register. Depends on lbp_pkg; commanded by lbp_ctrl.
`default_nettype none

module lbp_dpath
  import lbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] value,
  input  logic [CNT_W-1:0]   bit_count,
  input  logic               flush,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               o_valid,
  input  logic               o_ready,
  output logic [BYTE_W-1:0]  o_byte,
  output logic [VB_W-1:0]    o_valid_bits,
  output logic [TOT_W-1:0]   o_total,
  output logic               o_last
);

  logic [SREG_W-1:0] sreg_r, sreg_nxt;
  logic [CNT_W-1:0]  avail_r, avail_nxt;
  logic [PCNT_W-1:0] counted_r, counted_nxt;
  logic              flush_r, flush_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [TOT_W-1:0]  bw_r, bw_nxt;

  logic              o_vld_r, o_vld_nxt;
  logic [BYTE_W-1:0] o_byte_r, o_byte_nxt;
  logic [VB_W-1:0]   o_vb_r, o_vb_nxt;
  logic [TOT_W-1:0]  o_tot_r, o_tot_nxt;
  logic              o_last_r, o_last_nxt;

  logic [CNT_W-1:0]   n_cl;
  logic [VALUE_W-1:0] mask;
  logic [PCNT_W-1:0]  rem;
  logic [CNT_W-1:0]   avail_after;
  logic [VB_W-1:0]    add_val;
  logic [TOT_W:0]     sum;
  logic [TOT_W-1:0]   bw_sat;

  assign n_cl = (bit_count > CNT_W'(MAX_CHUNK_BITS)) ? CNT_W'(MAX_CHUNK_BITS) : bit_count;
  assign mask = (n_cl >= CNT_W'(VALUE_W)) ? {VALUE_W{1'b1}}
                                          : ~({VALUE_W{1'b1}} << n_cl[5:0]);
  assign rem         = avail_r[PCNT_W-1:0];
  assign avail_after = avail_r - CNT_W'(BYTE_W);

  assign add_val = cmd.emit_full ? (VB_W'(BYTE_W) - {1'b0, counted_r})
                                 : ({1'b0, rem} - {1'b0, counted_r});
  assign sum     = {1'b0, bw_r} + (TOT_W + 1)'(add_val);
  assign bw_sat  = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];

  assign sts.has_byte  = (avail_r >= CNT_W'(BYTE_W));
  assign sts.part_emit = flush_r && (rem != '0);
  assign sts.out_free  = !o_vld_r || o_ready;

  always_comb begin
    sreg_nxt    = sreg_r;
    avail_nxt   = avail_r;
    counted_nxt = counted_r;
    flush_nxt   = flush_r;
    pend_nxt    = pend_r;
    pcnt_nxt    = pcnt_r;
    bw_nxt      = bw_r;
    o_vld_nxt   = o_vld_r && !o_ready;
    o_byte_nxt  = o_byte_r;
    o_vb_nxt    = o_vb_r;
    o_tot_nxt   = o_tot_r;
    o_last_nxt  = o_last_r;
    if (cmd.load) begin
      sreg_nxt    = ({PEND_W'(0), value & mask} << pcnt_r) | SREG_W'(pend_r);
      avail_nxt   = CNT_W'(pcnt_r) + n_cl;
      counted_nxt = pcnt_r;
      flush_nxt   = flush;
    end
    if (cmd.emit_full) begin
      sreg_nxt    = sreg_r >> BYTE_W;
      avail_nxt   = avail_after;
      counted_nxt = '0;
      bw_nxt      = bw_sat;
      o_vld_nxt   = 1'b1;
      o_byte_nxt  = sreg_r[BYTE_W-1:0];
      o_vb_nxt    = VB_W'(BYTE_W);
      o_tot_nxt   = bw_sat;
      o_last_nxt  = (avail_after < CNT_W'(BYTE_W)) && !(flush_r && (avail_after != '0));
    end
    if (cmd.finish) begin
      bw_nxt   = bw_sat;
      pend_nxt = flush_r ? '0 : sreg_r[PEND_W-1:0];
      pcnt_nxt = flush_r ? '0 : rem;
      if (flush_r && (rem != '0)) begin
        o_vld_nxt  = 1'b1;
        o_byte_nxt = sreg_r[BYTE_W-1:0];
        o_vb_nxt   = {1'b0, rem};
        o_tot_nxt  = bw_sat;
        o_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      pcnt_r  <= '0;
      bw_r    <= '0;
      o_vld_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      pcnt_r  <= pcnt_nxt;
      bw_r    <= bw_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sreg_r    <= sreg_nxt;
    avail_r   <= avail_nxt;
    counted_r <= counted_nxt;
    flush_r   <= flush_nxt;
    o_byte_r  <= o_byte_nxt;
    o_vb_r    <= o_vb_nxt;
    o_tot_r   <= o_tot_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign o_valid      = o_vld_r;
  assign o_byte       = o_byte_r;
  assign o_valid_bits = o_vb_r;
  assign o_total      = o_tot_r;
  assign o_last       = o_last_r;

endmodule

`default_nettype wire

/* design/lsb_first_bit_packer.sv */
// LSB-first variable-length bit packer, top level.
// Input item: in_tdata = {pad, bit_count, value}, in_tlast = flush. Each item
// appends the low bit_count bits of value (clamped to 64) to a byte stream,
// bit 0 first; every completed byte leaves on the out_ channel.
// With in_tlast set, a remaining partial byte also leaves, zero padded.
// Output item: out_tdata = {total_bits, out_byte}, out_tuser = valid_bits,
// out_tlast marks the final byte caused by an input item.
// Sequence: an item is taken in the idle state, then each full byte goes through the
// shared output register, waiting while that register is still held by the
// receiver, then a finish step updates the pending bits and also sends a flushed
// partial byte. in_tready is high only between items, so an item's sequence is
// finished before the next item is taken.
// When the receiver stalls, the output register holds its byte and the
// emission sequence waits; no byte is lost.
// Reset clears pending bits, the running bit count and the output valid.
// Depends on lbp_pkg, lbp_ctrl, lbp_dpath.
`default_nettype none

module lsb_first_bit_packer
  import lbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[63:0], bit_count[70:64], zero[71]
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte[7:0], total_bits[39:8]
  output logic [VB_W-1:0]        out_tuser,  // valid_bits[3:0]
  output logic                   out_tlast
);

  cmd_t              cmd;
  sts_t              sts;
  logic [BYTE_W-1:0] o_byte;
  logic [TOT_W-1:0]  o_total;

  lbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbp_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .value        (in_tdata[VALUE_W-1:0]),
    .bit_count    (in_tdata[VALUE_W+CNT_W-1:VALUE_W]),
    .flush        (in_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .o_valid      (out_tvalid),
    .o_ready      (out_tready),
    .o_byte       (o_byte),
    .o_valid_bits (out_tuser),
    .o_total      (o_total),
    .o_last       (out_tlast)
  );

  assign out_tdata = {o_total, o_byte};

endmodule

`default_nettype wire

/* design/lbp_checker.sv */
// Port-level checks for lsb_first_bit_packer, attached by bind.
// Depends on lbp_pkg and the top level's ports.
`default_nettype none

module lbp_checker
  import lbp_pkg::*;
(
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_tvalid,
  input wire                   in_tready,
  input wire                   out_tvalid,
  input wire                   out_tready,
  input wire [OUT_TDATA_W-1:0] out_tdata,
  input wire [VB_W-1:0]        out_tuser,
  input wire                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out item changed while stalled");

  a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != '0) && (out_tuser <= VB_W'(BYTE_W)))
    else $error("valid bit count out of range");

  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != VB_W'(BYTE_W)) |-> out_tlast)
    else $error("partial byte not marked last");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* test/tb.sv */
// Testbench for lsb_first_bit_packer: directed table, then random items, with random
// idling on both streams and one long receiver stall. Output is checked against an
// in-bench bit packing predictor or table values. Depends on lbp_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;
  import lbp_pkg::*;

  localparam int N_PLAN      = 19;
  localparam int N_RAND      = 400;
  localparam int N_CALM      = 80;
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN       = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINT   = 40;

  typedef enum logic [1:0] {CHK_NONE, CHK_ONE, CHK_MODEL} row_chk_t;

  typedef struct packed {
    logic [7:0]  octet;
    logic [3:0]  nbits;
    logic [31:0] total;
    logic        last;
  } packed_octet_t;

  typedef struct packed {
    logic [63:0] value;
    logic [6:0]  cnt;
    logic        flush;
    row_chk_t    chk;
    logic [7:0]  octet;
    logic [3:0]  nbits;
    logic [31:0] total;
  } plan_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [VB_W-1:0]        out_tuser;
  logic                   out_tlast;

  packed_octet_t octets_due [$];
  packed_octet_t head;
  logic [6:0]    pend_bits  = '0;
  int unsigned   pend_cnt   = 0;
  logic [31:0]   bits_total = '0;
  int unsigned   mismatches = 0;
  int unsigned   cycles     = 0;
  bit            calm       = 1'b0;

  plan_row_t plan [N_PLAN] = '{
    '{64'h0000_0000_0000_00A5, 7'd8,   1'b0, CHK_ONE,   8'hA5, 4'd8, 32'd8},
    '{64'h0000_0000_0000_0000, 7'd0,   1'b0, CHK_NONE,  8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0000, 7'd0,   1'b1, CHK_NONE,  8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0001, 7'd1,   1'b1, CHK_ONE,   8'h01, 4'd1, 32'd9},
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  1'b0, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0000, 7'd64,  1'b1, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0003, 7'd65,  1'b0, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0005, 7'd3,   1'b0, CHK_NONE,  8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_007F, 7'd7,   1'b0, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0000, 7'd0,   1'b1, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h8000_0000_0000_0000, 7'd64,  1'b1, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h5555_5555_5555_5555, 7'd63,  1'b1, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'hDEAD_BEEF_0123_4567, 7'd13,  1'b0, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'h0123_4567_89AB_CDEF, 7'd7,   1'b1, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, CHK_MODEL, 8'h00, 4'd0, 32'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   1'b1, CHK_NONE,  8'h00, 4'd0, 32'd0},
    '{64'hFFFF_FFFF_FFFF_FFFE, 7'd1,   1'b0, CHK_NONE,  8'h00, 4'd0, 32'd0},
    '{64'h0000_0000_0000_0000, 7'd0,   1'b1, CHK_ONE,   8'h00, 4'd1, 32'd487}
  };

  lsb_first_bit_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append the item to the predicted stream and, if keep is set, queue the bytes it completes
  function automatic void pack_bits(input logic [63:0] val, input logic [6:0] cnt,
                                    input logic flush, input bit keep);
    packed_octet_t made [9];
    logic [7:0]    acc;
    int unsigned   n;
    int unsigned   fill;
    int unsigned   k;
    n    = (cnt > MAX_CHUNK_BITS) ? MAX_CHUNK_BITS : cnt;
    acc  = {1'b0, pend_bits};
    fill = pend_cnt;
    k    = 0;
    for (int unsigned i = 0; i < n; i++) begin
      acc[fill] = val[i];
      fill++;
      if (bits_total != '1) bits_total++;
      if (fill == 8) begin
        made[k] = '{acc, 4'd8, bits_total, 1'b0};
        k++;
        acc  = '0;
        fill = 0;
      end
    end
    if (flush && fill != 0) begin
      made[k] = '{acc, 4'(fill), bits_total, 1'b0};
      k++;
      acc  = '0;
      fill = 0;
    end
    if (k != 0) made[k-1].last = 1'b1;
    if (keep) begin
      for (int unsigned j = 0; j < k; j++) octets_due.push_back(made[j]);
    end
    pend_bits = acc[6:0];
    pend_cnt  = fill;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINT)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic send_item(input plan_row_t row);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, row.cnt, row.value};
    in_tlast  <= row.flush;
    do @(posedge clk); while (!in_tready);
    pack_bits(row.value, row.cnt, row.flush, row.chk == CHK_MODEL);
    if (row.chk == CHK_ONE) octets_due.push_back('{row.octet, row.nbits, row.total, 1'b1});
  endtask

  initial begin : stim
    plan_row_t row;
    int        pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_PLAN; i++) send_item(plan[i]);
    for (int i = 0; i < N_RAND; i++) begin
      if (i >= N_RAND - N_CALM) calm = 1'b1;
      row       = '0;
      row.chk   = CHK_MODEL;
      row.value = {$urandom, $urandom};
      pick      = $urandom_range(0, 9);
      case (pick)
        0: row.cnt = 7'd0;
        1: row.cnt = 7'd64;
        2: row.cnt = 7'($urandom_range(65, 127));
        default: row.cnt = 7'($urandom_range(1, 63));
      endcase
      row.flush = ($urandom_range(0, 3) == 0);
      send_item(row);
    end
    in_tvalid <= 1'b0;
    while (octets_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("lsb_first_bit_packer test passed");
    end else begin
      $display("lsb_first_bit_packer test failed");
    end
    $finish;
  end

  // receiver side: random stalls, one long hold-off to back up the input
  initial begin : rx_side
    int n;
    int seen;
    bit held;
    seen = 0;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && seen >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        n = HOLD_LEN;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 12);
      end else begin
        out_tready <= 1'b1;
        n = 1;
      end
      repeat (n) @(posedge clk);
      seen += n;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (octets_due.size() == 0) begin
        note_mismatch("unexpected item", 64'(out_tdata), 64'd0);
      end else begin
        head = octets_due.pop_front();
        if (out_tdata[7:0] != head.octet)
          note_mismatch("out_byte", 64'(out_tdata[7:0]), 64'(head.octet));
        if (out_tuser != head.nbits)
          note_mismatch("valid_bits", 64'(out_tuser), 64'(head.nbits));
        if (out_tdata[39:8] != head.total)
          note_mismatch("total_bits", 64'(out_tdata[39:8]), 64'(head.total));
        if (out_tlast != head.last)
          note_mismatch("last_of_run", 64'(out_tlast), 64'(head.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lsb_first_bit_packer test failed");
      $finish;
    end
  end

endmodule
